>>> rtl/rwr_pkg.sv
// Shared types and constants for the reorder window reassembly block.
package rwr_pkg;

  localparam int WINDOW_DEF   = 32;
  localparam int SLOTS        = 64;
  localparam int SLOT_W       = 6;
  localparam int KEY_W        = 48;
  localparam int SIZE_W       = 21;
  localparam int ID_W         = 16;
  localparam int GEN_W        = 32;
  localparam int DATA_W       = 16;
  localparam int QDEPTH       = 2;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 21'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POS_WHOLE  = 2'd0,
    POS_FIRST  = 2'd1,
    POS_MIDDLE = 2'd2,
    POS_FINAL  = 2'd3
  } pos_t;

  typedef enum logic {
    ADDR_MAX_SIZE = 1'b0,
    ADDR_START_ID = 1'b1
  } reg_addr_t;

  // Classified item handed from front to back.
  typedef enum logic [1:0] {
    CMD_RELEASE = 2'd0,
    CMD_ERROR   = 2'd1,
    CMD_PARK    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    status_t            err;
    logic [SLOT_W-1:0]  slot;
    logic               frag;
    logic               comp;
    logic [DATA_W-1:0]  handle;
    logic [DATA_W-1:0]  length;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DRAIN = 2'd1,
    BK_READ  = 2'd2
  } bk_state_t;

endpackage

>>> rtl/rwr_front.sv
// Front part: forms keys, checks window and queue occupancy, classifies items.
module rwr_front #(
  parameter int WINDOW = rwr_pkg::WINDOW_DEF
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rwr_pkg::ID_W-1:0]    in_packet_id,
  input  logic [rwr_pkg::GEN_W-1:0]   in_generation,
  input  logic                        in_fragmented,
  input  logic                        in_compressed,
  input  logic [rwr_pkg::DATA_W-1:0]  in_payload_handle,
  input  logic [rwr_pkg::DATA_W-1:0]  in_payload_length,
  // view of back state; valid only when back is idle and queue empty
  input  logic                        quiet,
  input  logic [rwr_pkg::KEY_W-1:0]   expected_key,
  input  logic [rwr_pkg::SLOTS-1:0]   slot_valid,
  input  logic [rwr_pkg::SLOT_W:0]    queued_count,
  output logic                        cmd_push,
  output rwr_pkg::cmd_t               cmd
);
  logic [rwr_pkg::KEY_W-1:0] key;
  logic [rwr_pkg::KEY_W-1:0] ahead;
  logic [rwr_pkg::SLOT_W-1:0] slot;

  // the back updates expected_key and slots per item, so classify only when quiet
  assign in_ready = quiet;
  assign key  = {in_generation, in_packet_id};
  assign ahead = key - expected_key;
  assign slot = key[rwr_pkg::SLOT_W-1:0];

  always_comb begin
    cmd_push   = 1'b0;
    cmd.kind   = rwr_pkg::CMD_RELEASE;
    cmd.err    = rwr_pkg::ST_OK;
    cmd.slot   = slot;
    cmd.frag   = in_fragmented;
    cmd.comp   = in_compressed;
    cmd.handle = in_payload_handle;
    cmd.length = in_payload_length;
    if (in_valid && in_ready && key >= expected_key) begin
      if (key == expected_key) begin
        cmd_push = 1'b1;
      end else if (ahead > rwr_pkg::KEY_W'(WINDOW)) begin
        cmd_push = 1'b1;
        cmd.kind = rwr_pkg::CMD_ERROR;
        cmd.err  = rwr_pkg::ST_OUTSIDE;
      end else if (!slot_valid[slot]) begin
        cmd_push = 1'b1;
        if (queued_count >= (rwr_pkg::SLOT_W+1)'(WINDOW)) begin
          cmd.kind = rwr_pkg::CMD_ERROR;
          cmd.err  = rwr_pkg::ST_FULL;
        end else begin
          cmd.kind = rwr_pkg::CMD_PARK;
        end
      end
    end
  end
endmodule

>>> rtl/rwr_queue.sv
// Short command queue between front and back.
module rwr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rwr_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output logic          is_empty,
  output rwr_pkg::cmd_t head
);
  rwr_pkg::cmd_t mem_r [rwr_pkg::QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign not_empty = cnt_r != 2'd0;
  assign is_empty  = cnt_r == 2'd0;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

>>> rtl/rwr_back.sv
// Back part: slot ring, release, drain and fragment length check.
module rwr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  rwr_pkg::cmd_t               q_head,
  output logic                        q_pop,
  input  logic [rwr_pkg::SIZE_W-1:0]  max_size,
  input  logic                        restart,
  input  logic [rwr_pkg::ID_W-1:0]    start_id,
  output logic                        idle,
  output logic [rwr_pkg::KEY_W-1:0]   expected_key,
  output logic [rwr_pkg::SLOTS-1:0]   slot_valid,
  output logic [rwr_pkg::SLOT_W:0]    queued_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rwr_pkg::DATA_W-1:0]  out_handle,
  output logic [rwr_pkg::DATA_W-1:0]  out_length,
  output logic [1:0]                  out_position,
  output logic                        out_needs_decompress,
  output logic [1:0]                  out_status,
  output logic                        out_last
);
  localparam int W = rwr_pkg::DATA_W;

  logic [1+1+2*W-1:0] mem_r [rwr_pkg::SLOTS];
  logic [1+1+2*W-1:0] rd_r;

  rwr_pkg::bk_state_t state_r, state_nxt;
  logic [rwr_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [rwr_pkg::SLOTS-1:0]  sv_r, sv_nxt;
  logic [rwr_pkg::SLOT_W:0]   qc_r, qc_nxt;
  logic                       asm_r, asm_nxt, acomp_r, acomp_nxt;
  logic [rwr_pkg::SIZE_W-1:0] alen_r, alen_nxt;

  logic ov_r, ov_nxt;
  logic [W-1:0] oh_r, oh_nxt, ol_r, ol_nxt;
  logic [1:0] op_r, op_nxt, os_r, os_nxt;
  logic ond_r, ond_nxt, olast_r, olast_nxt;

  logic wr_en;
  logic [rwr_pkg::SLOT_W-1:0] rd_addr;
  logic out_free;

  // release inputs
  logic rel_go, rel_frag, rel_comp;
  logic [W-1:0] rel_h, rel_l;
  logic [rwr_pkg::SIZE_W-1:0] room;
  logic [rwr_pkg::KEY_W-1:0] key_inc;
  logic [rwr_pkg::SLOT_W-1:0] nslot;

  assign out_free     = !ov_r || out_ready;
  assign idle         = state_r == rwr_pkg::BK_IDLE;
  assign expected_key = key_r;
  assign slot_valid   = sv_r;
  assign queued_count = qc_r;
  assign key_inc      = key_r + rwr_pkg::KEY_W'(1);
  assign nslot        = key_inc[rwr_pkg::SLOT_W-1:0];
  assign room = (max_size >= alen_r) ? max_size - alen_r : '0;

  assign out_valid            = ov_r;
  assign out_handle           = oh_r;
  assign out_length           = ol_r;
  assign out_position         = op_r;
  assign out_needs_decompress = ond_r;
  assign out_status           = os_r;
  assign out_last             = olast_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[q_head.slot] <= {q_head.frag, q_head.comp, q_head.handle, q_head.length};
    rd_r <= mem_r[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt = key_r; sv_nxt = sv_r; qc_nxt = qc_r;
    asm_nxt = asm_r; acomp_nxt = acomp_r; alen_nxt = alen_r;
    ov_nxt = ov_r && !out_ready;
    oh_nxt = oh_r; ol_nxt = ol_r; op_nxt = op_r; os_nxt = os_r;
    ond_nxt = ond_r; olast_nxt = olast_r;
    // read the slot of the current key; it stays in rd_r while the drain stalls
    q_pop = 1'b0; wr_en = 1'b0; rd_addr = key_r[rwr_pkg::SLOT_W-1:0];
    rel_go = 1'b0; rel_frag = q_head.frag; rel_comp = q_head.comp;
    rel_h = q_head.handle; rel_l = q_head.length;

    case (state_r)
      rwr_pkg::BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_head.kind)
            rwr_pkg::CMD_PARK: begin
              wr_en = 1'b1;
              sv_nxt[q_head.slot] = 1'b1;
              qc_nxt = qc_r + (rwr_pkg::SLOT_W+1)'(1);
            end
            rwr_pkg::CMD_ERROR: begin
              ov_nxt = 1'b1; oh_nxt = q_head.handle; ol_nxt = q_head.length;
              op_nxt = rwr_pkg::POS_WHOLE; ond_nxt = 1'b0;
              os_nxt = q_head.err; olast_nxt = 1'b1;
            end
            default: rel_go = 1'b1;
          endcase
        end
      end
      rwr_pkg::BK_READ: begin
        // slot data lands in rd_r at the end of this cycle
        state_nxt = rwr_pkg::BK_DRAIN;
      end
      rwr_pkg::BK_DRAIN: begin
        if (out_free) begin
          rel_go = 1'b1;
          rel_frag = rd_r[2*W+1]; rel_comp = rd_r[2*W];
          rel_h = rd_r[2*W-1:W]; rel_l = rd_r[W-1:0];
        end
      end
      default: state_nxt = rwr_pkg::BK_IDLE;
    endcase

    if (rel_go) begin
      ov_nxt = 1'b1; oh_nxt = rel_h; ol_nxt = rel_l; os_nxt = rwr_pkg::ST_OK;
      if (rwr_pkg::SIZE_W'(rel_l) > room) begin
        op_nxt = rwr_pkg::POS_WHOLE; ond_nxt = 1'b0; os_nxt = rwr_pkg::ST_TOO_BIG;
        asm_nxt = 1'b0; acomp_nxt = 1'b0; alen_nxt = '0;
        olast_nxt = 1'b1; state_nxt = rwr_pkg::BK_IDLE;
      end else begin
        if (!asm_r) begin
          ond_nxt = rel_comp;
          if (!rel_frag) begin
            op_nxt = rwr_pkg::POS_WHOLE;
          end else begin
            op_nxt = rwr_pkg::POS_FIRST;
            asm_nxt = 1'b1; acomp_nxt = rel_comp; alen_nxt = rwr_pkg::SIZE_W'(rel_l);
          end
        end else begin
          ond_nxt = acomp_r;
          if (!rel_frag) begin
            op_nxt = rwr_pkg::POS_MIDDLE;
            alen_nxt = alen_r + rwr_pkg::SIZE_W'(rel_l);
          end else begin
            op_nxt = rwr_pkg::POS_FINAL;
            asm_nxt = 1'b0; acomp_nxt = 1'b0; alen_nxt = '0;
          end
        end
        key_nxt = key_inc;
        // continue draining if the successor is parked
        if (sv_r[nslot]) begin
          sv_nxt[nslot] = 1'b0;
          qc_nxt = qc_r - (rwr_pkg::SLOT_W+1)'(1);
          olast_nxt = 1'b0;
          state_nxt = rwr_pkg::BK_READ;
        end else begin
          olast_nxt = 1'b1;
          state_nxt = rwr_pkg::BK_IDLE;
        end
      end
    end

    if (restart) begin
      key_nxt = {{(rwr_pkg::KEY_W-rwr_pkg::ID_W){1'b0}}, start_id};
      sv_nxt = '0; qc_nxt = '0; asm_nxt = 1'b0; acomp_nxt = 1'b0; alen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwr_pkg::BK_IDLE;
      key_r <= '0; sv_r <= '0; qc_r <= '0;
      asm_r <= 1'b0; acomp_r <= 1'b0; alen_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      key_r <= key_nxt; sv_r <= sv_nxt; qc_r <= qc_nxt;
      asm_r <= asm_nxt; acomp_r <= acomp_nxt; alen_r <= alen_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oh_r <= oh_nxt; ol_r <= ol_nxt; op_r <= op_nxt; os_r <= os_nxt;
    ond_r <= ond_nxt; olast_r <= olast_nxt;
  end
endmodule

>>> rtl/reorder_window_reassembly.sv
// Top level: reorder window with fragment reassembly tagging.
//
//  channel | handshake        | payload
//  in_     | in_valid/ready   | packet_id, generation, flags, handle, length
//  out_    | out_valid/ready  | handle, length, position, decompress, status, last
//  cfg_    | APB psel/penable | max_command_size (0x0), start_packet_id (0x4)
//
// An in-order or parked item passes through front classification, the command queue and the back update.
// Draining handles each parked successor with a slot memory read followed by its release.
// Reset is synchronous on rst_n; all slots come up empty.
// in_ready is low while the back drains or the command queue is nonempty.
module reorder_window_reassembly #(
  parameter int WINDOW = rwr_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rwr_pkg::ID_W-1:0]    in_packet_id,
  input  logic [rwr_pkg::GEN_W-1:0]   in_generation,
  input  logic                        in_fragmented,
  input  logic                        in_compressed,
  input  logic [rwr_pkg::DATA_W-1:0]  in_payload_handle,
  input  logic [rwr_pkg::DATA_W-1:0]  in_payload_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rwr_pkg::DATA_W-1:0]  out_out_handle,
  output logic [rwr_pkg::DATA_W-1:0]  out_out_length,
  output logic [1:0]                  out_position,
  output logic                        out_needs_decompress,
  output logic [1:0]                  out_status,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  logic [rwr_pkg::SIZE_W-1:0] max_size_r;
  logic [rwr_pkg::ID_W-1:0]   start_id_r;
  logic cfg_wr, restart;
  logic quiet, bk_idle, q_ne, q_empty, q_pop, cmd_push;
  logic [rwr_pkg::KEY_W-1:0] exp_key;
  logic [rwr_pkg::SLOTS-1:0] sv;
  logic [rwr_pkg::SLOT_W:0]  qc;
  rwr_pkg::cmd_t cmd, head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && paddr[2] == rwr_pkg::ADDR_START_ID;
  assign prdata  = (paddr[2] == rwr_pkg::ADDR_START_ID) ? {16'd0, start_id_r}
                                                        : {11'd0, max_size_r};
  assign quiet   = bk_idle && q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= rwr_pkg::MAX_SIZE_RST;
      start_id_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == rwr_pkg::ADDR_START_ID) start_id_r <= pwdata[rwr_pkg::ID_W-1:0];
      else max_size_r <= pwdata[rwr_pkg::SIZE_W-1:0];
    end
  end

  rwr_front #(.WINDOW(WINDOW)) u_front (
    .in_valid, .in_ready, .in_packet_id, .in_generation,
    .in_fragmented, .in_compressed, .in_payload_handle, .in_payload_length,
    .quiet, .expected_key(exp_key), .slot_valid(sv), .queued_count(qc),
    .cmd_push, .cmd
  );

  rwr_queue u_queue (
    .clk, .rst_n, .push(cmd_push), .push_data(cmd), .pop(q_pop),
    .not_empty(q_ne), .is_empty(q_empty), .head
  );

  rwr_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_head(head), .q_pop,
    .max_size(max_size_r), .restart, .start_id(pwdata[rwr_pkg::ID_W-1:0]),
    .idle(bk_idle), .expected_key(exp_key), .slot_valid(sv), .queued_count(qc),
    .out_valid, .out_ready, .out_handle(out_out_handle), .out_length(out_out_length),
    .out_position, .out_needs_decompress, .out_status, .out_last
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_handle))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !bk_idle |-> !in_ready)
    else $error("input taken while draining");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    qc == 7'($countones(sv)))
    else $error("queued count out of step with slot bits");
  a_err_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rwr_pkg::ST_OK |-> out_position == rwr_pkg::POS_WHOLE
      && out_last)
    else $error("error result malformed");
endmodule
